[hw/rtl/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the poly-X tail trimmer.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int unsigned FIELD_W    = 13;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned MASK_W     = 5;
  localparam int unsigned NUM_KINDS  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  localparam logic [CODE_W-1:0] KIND_N = 3'd4;

  localparam logic [FIELD_W-1:0] MIN_COMPARE_RST      = 13'd10;
  localparam logic [FIELD_W-1:0] MAX_MISMATCH_RST     = 13'd5;
  localparam logic [FIELD_W-1:0] ONE_MISMATCH_PER_RST = 13'd8;
  localparam logic [MASK_W-1:0]  BASE_MASK_RST        = 5'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_COMPARE      = 2'd0,
    CFG_MAX_MISMATCH     = 2'd1,
    CFG_ONE_MISMATCH_PER = 2'd2,
    CFG_BASE_MASK        = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_SCAN = 2'd0,
    BK_DIV  = 2'd1,
    BK_DONE = 2'd2
  } back_state_e;

  typedef struct packed {
    logic [FIELD_W-1:0] min_compare;
    logic [FIELD_W-1:0] max_mismatch;
    logic [FIELD_W-1:0] one_mismatch_per;
    logic [MASK_W-1:0]  base_mask;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] kind;
    logic              last;
  } item_t;

endpackage

[hw/rtl/ptt_front.sv]
// ----------------------------------------------------------------------------
// ptt_front
// Accepts base beats, folds unknown codes into N and pushes them to the queue.
// ----------------------------------------------------------------------------
module ptt_front (
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ptt_pkg::CODE_W-1:0] base_code_i,
  input  logic                       read_start_i,
  output logic                       push_o,
  output ptt_pkg::item_t             push_item_o,
  input  logic                       full_i
);
  import ptt_pkg::*;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    push_item_o.kind = (base_code_i > KIND_N) ? KIND_N : base_code_i;
    push_item_o.last = read_start_i;
  end

endmodule

[hw/rtl/ptt_fifo.sv]
// ----------------------------------------------------------------------------
// ptt_fifo
// Short queue of classified bases between front and back.
// ----------------------------------------------------------------------------
module ptt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ptt_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ptt_pkg::item_t pop_item_o
);
  import ptt_pkg::*;

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign full_o     = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[hw/rtl/ptt_back.sv]
// ----------------------------------------------------------------------------
// ptt_back
// Scans queued bases, keeps the running mismatch allowance and emits the
// per-read trim result through an output register.
// ----------------------------------------------------------------------------
module ptt_back #(
  parameter int unsigned MAX_READ_LEN = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ptt_pkg::cfg_t               cfg_i,
  input  logic                        div_start_i,
  input  logic                        item_valid_i,
  input  ptt_pkg::item_t              item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        trim_done_o,
  output logic [ptt_pkg::CODE_W-1:0]  tail_base_o,
  output logic [ptt_pkg::FIELD_W-1:0] tail_length_o,
  output logic [ptt_pkg::FIELD_W-1:0] kept_length_o
);
  import ptt_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_READ_LEN + 1);
  localparam int unsigned AW  = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int unsigned TW  = (CW + 1 > FIELD_W) ? CW + 1 : FIELD_W;
  localparam int unsigned DCW = $clog2(CW + 1);

  back_state_e state_q, state_d;

  logic [CW-1:0]      cnt_q  [NUM_KINDS];
  logic [CW-1:0]      last_q [NUM_KINDS];
  logic [NUM_KINDS-1:0] seen_q;
  logic [CW-1:0]      scan_pos_q, stop_pos_q, quo_q;
  logic               stopped_q;
  logic [FIELD_W-1:0] rem_q;
  logic [DCW-1:0]     div_cnt_q;

  logic               out_valid_q, trim_q;
  logic [CODE_W-1:0]  base_q;
  logic [FIELD_W-1:0] tail_q, kept_q;

  logic               load_out;
  logic [FIELD_W-1:0] divisor;

  // scan step
  logic               active;
  logic [FIELD_W:0]   rem_inc;
  logic               wrap;
  logic [CW-1:0]      quo_inc;
  logic [AW-1:0]      allowed;
  logic [CW-1:0]      cmp;
  logic [CW-1:0]      cnt_new [NUM_KINDS];
  logic               keep;

  // divide step
  logic [FIELD_W:0]   r_sh;
  logic               ge;
  logic [FIELD_W-1:0] r_next;

  // finish
  logic [CW-1:0]      fin_pos;
  logic [TW-1:0]      fin_pos1;
  logic               fin_trim;
  logic [CODE_W-1:0]  fin_best;
  logic [CW-1:0]      fin_tail;
  logic [CW-1:0]      fin_kept;

  assign divisor = (cfg_i.one_mismatch_per == '0) ? FIELD_W'(1)
                                                  : cfg_i.one_mismatch_per;

  always_comb begin
    active  = (scan_pos_q < CW'(MAX_READ_LEN));
    rem_inc = {1'b0, rem_q} + 1'b1;
    wrap    = (rem_inc >= {1'b0, divisor});
    quo_inc = wrap ? quo_q + 1'b1 : quo_q;
    allowed = AW'(quo_inc);
    if (allowed == '0) begin
      allowed = AW'(1);
    end
    if (allowed > AW'(cfg_i.max_mismatch)) begin
      allowed = AW'(cfg_i.max_mismatch);
    end
    cmp  = scan_pos_q + 1'b1;
    keep = 1'b0;
    for (int k = 0; k < NUM_KINDS; k++) begin
      cnt_new[k] = (item_i.kind == CODE_W'(k)) ? cnt_q[k] + 1'b1 : cnt_q[k];
      if (cfg_i.base_mask[k] && (AW'(cmp - cnt_new[k]) <= allowed)) begin
        keep = 1'b1;
      end
    end
  end

  always_comb begin
    r_sh   = {rem_q, quo_q[CW-1]};
    ge     = (r_sh >= {1'b0, divisor});
    r_next = ge ? FIELD_W'(r_sh - {1'b0, divisor}) : FIELD_W'(r_sh);
  end

  always_comb begin
    logic [CW-1:0] best_cnt;
    logic          found;
    fin_pos  = stopped_q ? stop_pos_q : scan_pos_q;
    fin_pos1 = TW'(fin_pos) + 1'b1;
    fin_trim = (fin_pos1 >= TW'(cfg_i.min_compare));
    best_cnt = '0;
    found    = 1'b0;
    fin_best = '0;
    for (int k = 0; k < NUM_KINDS; k++) begin
      if (cfg_i.base_mask[k] && (!found || cnt_q[k] > best_cnt)) begin
        found    = 1'b1;
        best_cnt = cnt_q[k];
        fin_best = CODE_W'(k);
      end
    end
    if (!fin_trim) begin
      fin_best = '0;
      fin_tail = '0;
    end else begin
      fin_tail = (seen_q[fin_best] ? last_q[fin_best] : '0) + 1'b1;
    end
    fin_kept = scan_pos_q - fin_tail;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_SCAN: begin
        if (div_start_i) begin
          state_d = BK_DIV;
        end else if (item_valid_i && item_i.last) begin
          state_d = BK_DONE;
        end
      end
      BK_DIV: begin
        if (!div_start_i && div_cnt_q == DCW'(1)) begin
          state_d = BK_SCAN;
        end
      end
      BK_DONE: begin
        if (load_out) begin
          state_d = BK_SCAN;
        end
      end
      default: state_d = BK_SCAN;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_SCAN: pop_o    = item_valid_i && !div_start_i;
      BK_DIV:  pop_o    = 1'b0;
      BK_DONE: load_out = !out_valid_q || out_ready_i;
      default: pop_o    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_SCAN;
      out_valid_q <= 1'b0;
      seen_q      <= '0;
      scan_pos_q  <= '0;
      stop_pos_q  <= '0;
      stopped_q   <= 1'b0;
      quo_q       <= '0;
      rem_q       <= '0;
      div_cnt_q   <= '0;
      for (int k = 0; k < NUM_KINDS; k++) begin
        cnt_q[k]  <= '0;
        last_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (state_q == BK_DONE) begin
        if (load_out) begin
          seen_q     <= '0;
          scan_pos_q <= '0;
          stop_pos_q <= '0;
          stopped_q  <= 1'b0;
          quo_q      <= '0;
          rem_q      <= '0;
          for (int k = 0; k < NUM_KINDS; k++) begin
            cnt_q[k]  <= '0;
            last_q[k] <= '0;
          end
        end
      end else if (div_start_i) begin
        quo_q     <= scan_pos_q;
        rem_q     <= '0;
        div_cnt_q <= DCW'(CW);
      end else if (state_q == BK_DIV) begin
        quo_q     <= {quo_q[CW-2:0], ge};
        rem_q     <= r_next;
        div_cnt_q <= div_cnt_q - 1'b1;
      end else if (pop_o && active) begin
        quo_q      <= quo_inc;
        rem_q      <= wrap ? '0 : FIELD_W'(rem_inc);
        scan_pos_q <= cmp;
        if (!stopped_q) begin
          for (int k = 0; k < NUM_KINDS; k++) begin
            if (item_i.kind == CODE_W'(k)) begin
              cnt_q[k]  <= cnt_new[k];
              last_q[k] <= scan_pos_q;
              seen_q[k] <= 1'b1;
            end
          end
          if (!keep) begin
            stopped_q  <= 1'b1;
            stop_pos_q <= scan_pos_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      trim_q <= fin_trim;
      base_q <= fin_best;
      tail_q <= FIELD_W'(fin_tail);
      kept_q <= FIELD_W'(fin_kept);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign trim_done_o   = trim_q;
  assign tail_base_o   = base_q;
  assign tail_length_o = tail_q;
  assign kept_length_o = kept_q;

endmodule

[hw/rtl/poly_x_tail_trim.sv]
// ----------------------------------------------------------------------------
// poly_x_tail_trim
// A read's last base passes through the queue; in BK_DONE the back then loads
// the read's result into the output register. The front takes one base per
// cycle while the queue is not full; the back stalls to finish each read
// and while the quotient divider rebuilds after one_mismatch_per is written.
// Reset clears all per-read state and loads the register defaults at once.
// ----------------------------------------------------------------------------
module poly_x_tail_trim #(
  parameter int unsigned MAX_READ_LEN = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ptt_pkg::CODE_W-1:0]    base_code_i,
  input  logic                          read_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          trim_done_o,
  output logic [ptt_pkg::CODE_W-1:0]    tail_base_o,
  output logic [ptt_pkg::FIELD_W-1:0]   tail_length_o,
  output logic [ptt_pkg::FIELD_W-1:0]   kept_length_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ptt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ptt_pkg::FIELD_W-1:0]   cfg_data_i
);
  import ptt_pkg::*;

  cfg_t  cfg_q;
  logic  div_start_q;
  logic  cfg_we;
  logic  push, full, pop, q_valid;
  item_t push_item, pop_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_compare      <= MIN_COMPARE_RST;
      cfg_q.max_mismatch     <= MAX_MISMATCH_RST;
      cfg_q.one_mismatch_per <= ONE_MISMATCH_PER_RST;
      cfg_q.base_mask        <= BASE_MASK_RST;
      div_start_q            <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_MIN_COMPARE:  cfg_q.min_compare  <= cfg_data_i;
          CFG_MAX_MISMATCH: cfg_q.max_mismatch <= cfg_data_i;
          CFG_ONE_MISMATCH_PER: begin
            cfg_q.one_mismatch_per <= cfg_data_i;
            div_start_q            <= 1'b1;
          end
          CFG_BASE_MASK:    cfg_q.base_mask    <= cfg_data_i[MASK_W-1:0];
          default:          cfg_q              <= cfg_q;
        endcase
      end
    end
  end

  ptt_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .base_code_i  (base_code_i),
    .read_start_i (read_start_i),
    .push_o       (push),
    .push_item_o  (push_item),
    .full_i       (full)
  );

  ptt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  ptt_back #(
    .MAX_READ_LEN (MAX_READ_LEN)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .div_start_i   (div_start_q),
    .item_valid_i  (q_valid),
    .item_i        (pop_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .trim_done_o   (trim_done_o),
    .tail_base_o   (tail_base_o),
    .tail_length_o (tail_length_o),
    .kept_length_o (kept_length_o)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for poly_x_tail_trim. Drives reads one base per beat
// (3' end first), tracks per-read tail statistics in a local predictor, and
// checks each trim result field by field against the oldest expected trim.
// Covers default and extreme register settings, out-of-range base codes,
// random input idles and random backpressure on the output channel.
// ----------------------------------------------------------------------------
module tb_top;
  import ptt_pkg::*;

  localparam int unsigned MAX_LEN        = 4096;
  localparam int unsigned IDLE_PCT       = 22;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned BEATS_PER_SET  = 180;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam longint      TIMEOUT_NS     = 1_000_000;
  localparam logic [CODE_W-1:0]  CODE_MAX = '1;
  localparam logic [FIELD_W-1:0] FIELD_TOP = 13'd4096;

  typedef enum logic [CODE_W-1:0] {
    BASE_A = 3'd0,
    BASE_T = 3'd1,
    BASE_C = 3'd2,
    BASE_G = 3'd3,
    BASE_N = KIND_N
  } base_e;

  typedef struct packed {
    logic               trim_done;
    logic [CODE_W-1:0]  tail_base;
    logic [FIELD_W-1:0] tail_length;
    logic [FIELD_W-1:0] kept_length;
  } trim_result_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [CODE_W-1:0]    base_code_i  = '0;
  logic                 read_start_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic                 trim_done_o;
  logic [CODE_W-1:0]    tail_base_o;
  logic [FIELD_W-1:0]   tail_length_o;
  logic [FIELD_W-1:0]   kept_length_o;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [FIELD_W-1:0]   cfg_data_i   = '0;

  poly_x_tail_trim #(
    .MAX_READ_LEN(MAX_LEN)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .base_code_i  (base_code_i),
    .read_start_i (read_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .trim_done_o  (trim_done_o),
    .tail_base_o  (tail_base_o),
    .tail_length_o(tail_length_o),
    .kept_length_o(kept_length_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state
  logic [FIELD_W-1:0] cfg_min_compare  = MIN_COMPARE_RST;
  logic [FIELD_W-1:0] cfg_max_mismatch = MAX_MISMATCH_RST;
  logic [FIELD_W-1:0] cfg_one_per      = ONE_MISMATCH_PER_RST;
  logic [MASK_W-1:0]  cfg_base_mask    = BASE_MASK_RST;

  logic [FIELD_W-1:0] kind_count [NUM_KINDS];
  logic [FIELD_W-1:0] last_pos   [NUM_KINDS];
  logic               kind_seen  [NUM_KINDS];
  logic [FIELD_W-1:0] scan_pos;
  logic               scan_stopped;
  logic [FIELD_W-1:0] stop_pos;

  trim_result_t expected_trims [$];
  int unsigned  fail_cnt   = 0;
  int unsigned  beats_sent = 0;
  int unsigned  idle_pct   = IDLE_PCT;

  function automatic void clear_read_stats();
    for (int k = 0; k < NUM_KINDS; k++) begin
      kind_count[k] = '0;
      last_pos[k]   = '0;
      kind_seen[k]  = 1'b0;
    end
    scan_pos     = '0;
    scan_stopped = 1'b0;
    stop_pos     = '0;
  endfunction

  function automatic void track_base(input logic [CODE_W-1:0] code, input logic last);
    int unsigned  kind, cmp, divisor, allow, read_len, tail, poly;
    int           best;
    logic         keep;
    trim_result_t res;
    kind = (code > KIND_N) ? KIND_N : code;
    if (scan_pos < MAX_LEN) begin
      if (!scan_stopped) begin
        cmp     = scan_pos + 1;
        divisor = (cfg_one_per == 0) ? 1 : cfg_one_per;
        allow   = cmp / divisor;
        if (allow < 1) allow = 1;
        if (allow > cfg_max_mismatch) allow = cfg_max_mismatch;
        kind_count[kind] = kind_count[kind] + 1'b1;
        last_pos[kind]   = scan_pos;
        kind_seen[kind]  = 1'b1;
        keep = 1'b0;
        for (int k = 0; k < NUM_KINDS; k++) begin
          if (cfg_base_mask[k] && (cmp - kind_count[k]) <= allow) keep = 1'b1;
        end
        if (!keep) begin
          scan_stopped = 1'b1;
          stop_pos     = scan_pos;
        end
      end
      scan_pos = scan_pos + 1'b1;
    end
    if (last) begin
      read_len = scan_pos;
      tail     = 0;
      poly     = 0;
      res      = '0;
      if ((scan_stopped ? stop_pos : read_len) + 1 >= cfg_min_compare) begin
        best = -1;
        for (int k = 0; k < NUM_KINDS; k++) begin
          if (cfg_base_mask[k] && int'(kind_count[k]) > best) begin
            best = kind_count[k];
            poly = k;
          end
        end
        tail          = (kind_seen[poly] ? last_pos[poly] : 0) + 1;
        res.trim_done = 1'b1;
      end
      res.tail_base   = CODE_W'(poly);
      res.tail_length = FIELD_W'(tail);
      res.kept_length = FIELD_W'(read_len - tail);
      expected_trims.push_back(res);
      clear_read_stats();
    end
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    trim_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_trims.size() == 0) begin
        if (fail_cnt < MAX_REPORTS)
          $display("unexpected result beat: done=%0d base=%0d tail=%0d kept=%0d",
                   trim_done_o, tail_base_o, tail_length_o, kept_length_o);
        fail_cnt++;
      end else begin
        want = expected_trims.pop_front();
        if (trim_done_o !== want.trim_done || tail_base_o !== want.tail_base ||
            tail_length_o !== want.tail_length || kept_length_o !== want.kept_length) begin
          if (fail_cnt < MAX_REPORTS)
            $display({"mismatch: expected done=%0d base=%0d tail=%0d kept=%0d,",
                      " got done=%0d base=%0d tail=%0d kept=%0d"},
                     want.trim_done, want.tail_base, want.tail_length, want.kept_length,
                     trim_done_o, tail_base_o, tail_length_o, kept_length_o);
          fail_cnt++;
        end
      end
    end
  end

  task automatic send_base(input logic [CODE_W-1:0] code, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    base_code_i  <= code;
    read_start_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    track_base(code, last);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_trims.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [FIELD_W-1:0] min_cmp, max_mm, one_per,
                            input logic [MASK_W-1:0] mask);
    logic [FIELD_W-1:0] vals [4];
    cfg_idx_e           idx;
    drain_results();
    vals = '{min_cmp, max_mm, one_per, FIELD_W'(mask)};
    idx  = CFG_MIN_COMPARE;
    repeat (4) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[idx];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        CFG_MIN_COMPARE:      cfg_min_compare  = vals[idx];
        CFG_MAX_MISMATCH:     cfg_max_mismatch = vals[idx];
        CFG_ONE_MISMATCH_PER: cfg_one_per      = vals[idx];
        CFG_BASE_MASK:        cfg_base_mask    = vals[idx][MASK_W-1:0];
        default: ;
      endcase
      @(negedge clk_i);
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_read(input int unsigned len, tail_len, input logic [CODE_W-1:0] kind,
                           input int unsigned noise_pct);
    logic [CODE_W-1:0] code;
    for (int unsigned i = 0; i < len; i++) begin
      if (i < tail_len && $urandom_range(0, 99) >= noise_pct)
        code = (kind == KIND_N) ? CODE_W'($urandom_range(KIND_N, CODE_MAX)) : kind;
      else if ($urandom_range(0, 3) == 0)
        code = CODE_W'($urandom_range(KIND_N, CODE_MAX));
      else
        code = CODE_W'($urandom_range(BASE_A, BASE_G));
      send_base(code, i == len - 1);
    end
  endtask

  task automatic random_read();
    int unsigned       len, tail_len;
    logic [CODE_W-1:0] kind;
    len      = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
    kind     = CODE_W'($urandom_range(BASE_A, BASE_N));
    tail_len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, len) : 0;
    send_read(len, tail_len, kind, $urandom_range(0, 15));
  endtask

  task automatic run_reads(input int unsigned n_beats, input int unsigned pct, input bit hold_mid);
    int unsigned first;
    bit          held;
    idle_pct = pct;
    first    = beats_sent;
    held     = 1'b0;
    while (beats_sent - first < n_beats) begin
      if (hold_mid && !held && beats_sent - first >= n_beats / 2) begin
        drain_results();
        held = 1'b1;
      end
      random_read();
    end
    idle_pct = IDLE_PCT;
  endtask

  task automatic test_single_base();
    send_base(BASE_G, 1'b1);
  endtask

  task automatic test_poly_a_tail();
    repeat (10) send_base(BASE_A, 1'b0);
    send_base(BASE_C, 1'b0);
    send_base(BASE_T, 1'b1);
  endtask

  task automatic test_other_codes();
    send_base(CODE_MAX, 1'b0);
    send_base(KIND_N + 3'd2, 1'b0);
    send_base(KIND_N + 3'd1, 1'b0);
    repeat (6) send_base(BASE_N, 1'b0);
    send_base(BASE_G, 1'b1);
  endtask

  task automatic test_special_configs();
    // no kind enabled: stop at once, pick A, which is never seen
    set_config('0, MAX_MISMATCH_RST, ONE_MISMATCH_PER_RST, '0);
    send_base(BASE_C, 1'b0);
    send_base(BASE_T, 1'b1);
    // zero divisor behaves as one
    set_config('0, MAX_MISMATCH_RST, '0, 5'b00100);
    send_base(BASE_A, 1'b0);
    send_base(BASE_A, 1'b0);
    send_base(BASE_C, 1'b1);
  endtask

  task automatic test_random_reads();
    set_config(MIN_COMPARE_RST, MAX_MISMATCH_RST, ONE_MISMATCH_PER_RST, BASE_MASK_RST);
    run_reads(BEATS_PER_SET, IDLE_PCT, 1'b0);
    set_config('0, '0, 13'd1, 5'b00001);
    run_reads(BEATS_PER_SET, IDLE_PCT, 1'b0);
    set_config(FIELD_TOP, FIELD_TOP, FIELD_TOP, BASE_MASK_RST);
    run_reads(BEATS_PER_SET, IDLE_PCT, 1'b0);
    set_config(13'd1, FIELD_TOP, '0, BASE_MASK_RST);
    run_reads(BEATS_PER_SET, 0, 1'b0);
    set_config(MIN_COMPARE_RST, MAX_MISMATCH_RST, ONE_MISMATCH_PER_RST, BASE_MASK_RST);
    run_reads(BEATS_PER_SET, IDLE_PCT, 1'b1);
    repeat (5) begin
      set_config(($urandom_range(0, 9) == 0) ? FIELD_TOP : FIELD_W'($urandom_range(0, 24)),
                 ($urandom_range(0, 3) == 0) ? FIELD_TOP : FIELD_W'($urandom_range(0, 8)),
                 FIELD_W'($urandom_range(0, 12)),
                 MASK_W'($urandom_range(0, 31)));
      run_reads(BEATS_PER_SET, IDLE_PCT, 1'b0);
    end
  endtask

  initial begin
    clear_read_stats();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_single_base();
    test_poly_a_tail();
    test_other_codes();
    test_special_configs();
    test_random_reads();
    drain_results();
    if (fail_cnt == 0 && expected_trims.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[poly_x_tail_trim.f]
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_front.sv
hw/rtl/ptt_fifo.sv
hw/rtl/ptt_back.sv
hw/rtl/poly_x_tail_trim.sv
verif/tb_top.sv
